// ===== hdl/qtca_pkg.sv =====
`timescale 1ns / 1ps
package qtca_pkg;

  localparam int TIME_BITS  = 63;
  localparam int PRICE_BITS = 31;
  localparam int SIZE_BITS  = 48;
  localparam int DIV_CNT_W  = 6;

  localparam logic [3:0] IDX_END     = 4'd0;
  localparam logic [3:0] IDX_FIRST   = 4'd1;
  localparam logic [3:0] IDX_LAST    = 4'd2;
  localparam logic [3:0] IDX_MINGAP  = 4'd3;
  localparam logic [3:0] IDX_MAXGAP  = 4'd4;
  localparam logic [3:0] IDX_MINASK  = 4'd5;
  localparam logic [3:0] IDX_MAXBID  = 4'd6;
  localparam logic [3:0] IDX_MINSPR  = 4'd7;
  localparam logic [3:0] IDX_MAXSPR  = 4'd8;
  localparam logic [3:0] IDX_BIDSZ   = 4'd9;
  localparam logic [3:0] IDX_ASKSZ   = 4'd10;
  localparam logic [3:0] IDX_SELLIMB = 4'd11;
  localparam logic [3:0] IDX_BUYIMB  = 4'd12;
  localparam logic [3:0] IDX_UP      = 4'd13;
  localparam logic [3:0] IDX_DOWN    = 4'd14;

  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic                  req_type;
    logic [TIME_BITS-1:0]  tick_time;
    logic [PRICE_BITS-1:0] bid_price;
    logic [PRICE_BITS-1:0] ask_price;
    logic [SIZE_BITS-1:0]  bid_size;
    logic [SIZE_BITS-1:0]  ask_size;
  } in_item_t;

  typedef struct packed {
    logic [3:0]         stat_index;
    logic signed [63:0] stat_value;
    logic               stat_present;
    logic               last_of_candle;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_EMIT,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic       load;
    logic       upd;
    logic       last_only;
    logic       open;
    logic       close;
    logic       div_step;
    logic       set_bound;
    logic       emit;
    logic [3:0] emit_idx;
  } cmd_t;

  typedef struct packed {
    logic flush;
    logic ooo;
    logic zero;
    logic need_new;
    logic is_open;
    logic int_zero;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/qtca_ctrl.sv =====
`timescale 1ns / 1ps
module qtca_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  qtca_pkg::sts_t sts,
  output qtca_pkg::cmd_t cmd
);
  import qtca_pkg::*;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       last_word;

  assign last_word = sts.out_free && (cnt_r == IDX_DOWN);
  assign in_stall  = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= IDX_END;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        cnt_nxt = IDX_END;
        if (sts.flush) begin
          state_nxt = sts.is_open ? ST_EMIT : ST_IDLE;
        end else if (sts.ooo || sts.zero || !sts.need_new) begin
          state_nxt = ST_IDLE;
        end else if (sts.is_open) begin
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = sts.int_zero ? ST_IDLE : ST_DIV;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) cnt_nxt = cnt_r + 4'd1;
        if (last_word) begin
          if (sts.flush || sts.int_zero) state_nxt = ST_IDLE;
          else state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.emit_idx = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cmd.load = in_valid;
      end
      ST_DECIDE: begin
        if (!sts.flush) begin
          if (sts.ooo) cmd.last_only = 1'b1;
          else if (!sts.zero) begin
            if (!sts.need_new) cmd.upd = 1'b1;
            else if (!sts.is_open) cmd.open = 1'b1;
          end
        end
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
        if (last_word) begin
          if (sts.flush) cmd.close = 1'b1;
          else cmd.open = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step  = !sts.div_done;
        cmd.set_bound = sts.div_done;
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/qtca_dp.sv =====
`timescale 1ns / 1ps
module qtca_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  qtca_pkg::in_item_t  in_data,
  input  logic                cfg_valid,
  input  logic [62:0]         cfg_data,
  input  logic                out_stall,
  output logic                out_valid,
  output qtca_pkg::out_item_t out_data,
  input  qtca_pkg::cmd_t      cmd,
  output qtca_pkg::sts_t      sts
);
  import qtca_pkg::*;

  localparam logic [63:0] NEVER = '1;

  in_item_t               in_r;
  logic [TIME_BITS-1:0]   interval_r;
  logic [63:0]            bound_r;
  logic                   open_r;
  logic [TIME_BITS-1:0]   first_r, last_r, min_gap_r, max_gap_r;
  logic                   gap_seen_r;
  logic [PRICE_BITS-1:0]  low_ask_r, high_bid_r, low_bid_r, high_ask_r;
  logic signed [PRICE_BITS:0] min_spr_r, max_spr_r, up_r, down_r;
  logic [SIZE_BITS-1:0]   pk_bid_r, pk_ask_r;
  logic signed [SIZE_BITS:0] min_imb_r, max_imb_r;
  logic [TIME_BITS-1:0]   dvd_r;
  logic [63:0]            rem_r;
  logic [DIV_CNT_W-1:0]   div_cnt_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic signed [PRICE_BITS:0] spr, du, dd;
  logic signed [SIZE_BITS:0]  imb;
  logic [TIME_BITS-1:0]       gap;
  logic [63:0]                rem_sh, bound_calc;
  out_item_t                  word;

  assign spr = $signed({1'b0, in_r.ask_price}) - $signed({1'b0, in_r.bid_price});
  assign du  = $signed({1'b0, in_r.ask_price}) - $signed({1'b0, low_bid_r});
  assign dd  = $signed({1'b0, in_r.bid_price}) - $signed({1'b0, high_ask_r});
  assign imb = $signed({1'b0, in_r.ask_size}) - $signed({1'b0, in_r.bid_size});
  assign gap = in_r.tick_time - last_r;
  assign rem_sh = {rem_r[62:0], dvd_r[TIME_BITS-1]};
  assign bound_calc = {1'b0, in_r.tick_time} - rem_r + {1'b0, interval_r};

  assign sts.flush    = (in_r.req_type == REQ_FLUSH);
  assign sts.ooo      = (in_r.tick_time < last_r);
  assign sts.zero     = (in_r.bid_price == '0) || (in_r.ask_price == '0);
  assign sts.need_new = !open_r || ({1'b0, in_r.tick_time} > bound_r);
  assign sts.is_open  = open_r;
  assign sts.int_zero = (interval_r == '0);
  assign sts.div_done = (div_cnt_r == '0);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    word.stat_index     = cmd.emit_idx;
    word.last_of_candle = (cmd.emit_idx == IDX_DOWN);
    word.stat_present   = 1'b1;
    word.stat_value     = '0;
    case (cmd.emit_idx)
      IDX_END: begin
        word.stat_present = (bound_r != NEVER);
        word.stat_value   = (bound_r != NEVER) ? bound_r : 64'd0;
      end
      IDX_FIRST:   word.stat_value = 64'(first_r);
      IDX_LAST:    word.stat_value = 64'(last_r);
      IDX_MINGAP: begin
        word.stat_present = gap_seen_r;
        word.stat_value   = gap_seen_r ? 64'(min_gap_r) : 64'd0;
      end
      IDX_MAXGAP: begin
        word.stat_present = gap_seen_r;
        word.stat_value   = gap_seen_r ? 64'(max_gap_r) : 64'd0;
      end
      IDX_MINASK:  word.stat_value = 64'(low_ask_r);
      IDX_MAXBID:  word.stat_value = 64'(high_bid_r);
      IDX_MINSPR:  word.stat_value = 64'(min_spr_r);
      IDX_MAXSPR:  word.stat_value = 64'(max_spr_r);
      IDX_BIDSZ:   word.stat_value = 64'(pk_bid_r);
      IDX_ASKSZ:   word.stat_value = 64'(pk_ask_r);
      IDX_SELLIMB: word.stat_value = -64'(min_imb_r);
      IDX_BUYIMB:  word.stat_value = 64'(max_imb_r);
      IDX_UP:      word.stat_value = 64'(up_r);
      IDX_DOWN:    word.stat_value = 64'(down_r);
      default:     word.stat_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= '0;
      bound_r     <= '0;
      open_r      <= 1'b0;
      first_r     <= '0;
      last_r      <= '0;
      min_gap_r   <= '0;
      max_gap_r   <= '0;
      gap_seen_r  <= 1'b0;
      low_ask_r   <= '0;
      high_bid_r  <= '0;
      low_bid_r   <= '0;
      high_ask_r  <= '0;
      min_spr_r   <= '0;
      max_spr_r   <= '0;
      up_r        <= '0;
      down_r      <= '0;
      pk_bid_r    <= '0;
      pk_ask_r    <= '0;
      min_imb_r   <= '0;
      max_imb_r   <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) interval_r <= cfg_data;
      if (cmd.emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (cmd.close) open_r <= 1'b0;
      if (cmd.last_only) last_r <= in_r.tick_time;
      if (cmd.open) begin
        open_r     <= 1'b1;
        if (interval_r == '0) bound_r <= NEVER;
        first_r    <= in_r.tick_time;
        last_r     <= in_r.tick_time;
        high_bid_r <= in_r.bid_price;
        low_ask_r  <= in_r.ask_price;
        low_bid_r  <= in_r.bid_price;
        high_ask_r <= in_r.ask_price;
        min_spr_r  <= spr;
        max_spr_r  <= spr;
        pk_bid_r   <= in_r.bid_size;
        pk_ask_r   <= in_r.ask_size;
        min_imb_r  <= imb;
        max_imb_r  <= imb;
        up_r       <= '0;
        down_r     <= '0;
        min_gap_r  <= '0;
        max_gap_r  <= '0;
        gap_seen_r <= 1'b0;
        div_cnt_r  <= DIV_CNT_W'(TIME_BITS);
      end
      if (cmd.div_step) div_cnt_r <= div_cnt_r - 1'b1;
      if (cmd.set_bound) bound_r <= bound_calc;
      if (cmd.upd) begin
        if (in_r.bid_price > high_bid_r) high_bid_r <= in_r.bid_price;
        if (in_r.ask_price < low_ask_r) low_ask_r <= in_r.ask_price;
        if (spr < min_spr_r) min_spr_r <= spr;
        if (spr > max_spr_r) max_spr_r <= spr;
        if (du > up_r) up_r <= du;
        if (dd < down_r) down_r <= dd;
        if (in_r.bid_price < low_bid_r) low_bid_r <= in_r.bid_price;
        if (in_r.ask_price > high_ask_r) high_ask_r <= in_r.ask_price;
        if (!gap_seen_r || gap < min_gap_r) min_gap_r <= gap;
        if (!gap_seen_r || gap > max_gap_r) max_gap_r <= gap;
        gap_seen_r <= 1'b1;
        if (in_r.bid_size > pk_bid_r) pk_bid_r <= in_r.bid_size;
        if (in_r.ask_size > pk_ask_r) pk_ask_r <= in_r.ask_size;
        if (imb > max_imb_r) max_imb_r <= imb;
        if (imb < min_imb_r) min_imb_r <= imb;
        last_r <= in_r.tick_time;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_data;
    if (cmd.emit) out_r <= word;
    if (cmd.open) begin
      dvd_r <= in_r.tick_time;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[TIME_BITS-2:0], 1'b0};
      rem_r <= (rem_sh >= {1'b0, interval_r}) ? rem_sh - {1'b0, interval_r} : rem_sh;
    end
  end

endmodule

// ===== hdl/quote_tick_candle_aggregator_core.sv =====
`timescale 1ns / 1ps
// Quote tick in an open candle: loaded, updated in ST_DECIDE, ready again.
// Candle close: 15 result beats from one output register, 1 beat per cycle
// unless out_stall holds it; a new candle then runs a bit-serial boundary
// divide before its end bound is set (skipped when interval_ns is zero).
// Reset (rst_n low, synchronous) clears all candle state and interval_ns.
module quote_tick_candle_aggregator_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qtca_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qtca_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [62:0]         cfg_data
);
  import qtca_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  qtca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  qtca_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== hdl/qtca_checker.sv =====
`timescale 1ns / 1ps
module qtca_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input qtca_pkg::out_item_t out_data
);
  import qtca_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.last_of_candle == (out_data.stat_index == IDX_DOWN)))
    else $error("last_of_candle misplaced");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.stat_present |-> out_data.stat_value == 64'sd0)
    else $error("absent statistic not zero");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

endmodule

bind quote_tick_candle_aggregator_core qtca_checker u_qtca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
